@@ design/rgbhsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Widths, scale constants, register codes and the sideband type shared by
// the RGB565 to HSL classifier and its divider pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	// color channel and quotient widths
	localparam int unsigned CH_W   = 8;
	localparam int unsigned QUO_W  = 8;

	// hue lane: 40 * |diff| over max - min
	localparam int unsigned HNUM_W = 14;
	localparam int unsigned HDEN_W = 8;

	// saturation lane: dif * 240 over sum or 510 - sum
	localparam int unsigned SNUM_W = 16;
	localparam int unsigned SDEN_W = 9;

	// hue sector offsets
	localparam logic [CH_W-1:0] HUE_OFF_R_UP   = 8'd0;
	localparam logic [CH_W-1:0] HUE_OFF_R_DOWN = 8'd240;
	localparam logic [CH_W-1:0] HUE_OFF_G      = 8'd80;
	localparam logic [CH_W-1:0] HUE_OFF_B      = 8'd160;

	// top of the 0..240 scale
	localparam logic [CH_W-1:0] SCALE_MAX = 8'd240;

	// lightness is floor(8*sum/17): zero for sum up to 2, at most 120 for sum up to 257
	localparam logic [SDEN_W-1:0] SUM_DARK_MAX = 9'd2;
	localparam logic [SDEN_W-1:0] SUM_LOW_MAX  = 9'd257;
	localparam logic [SDEN_W-1:0] SUM_FULL     = 9'd510;

	// reciprocal of 17, exact for 8*sum below 4096
	localparam logic [11:0]  LIGHT_RECIP = 12'd3856;
	localparam int unsigned  LIGHT_SHIFT = 16;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_HUE_LOW    = 3'd0,
		REG_HUE_HIGH   = 3'd1,
		REG_SAT_LOW    = 3'd2,
		REG_SAT_HIGH   = 3'd3,
		REG_LIGHT_LOW  = 3'd4,
		REG_LIGHT_HIGH = 3'd5
	} cfg_reg_t;

	// values that ride alongside the divider
	typedef struct packed {
		logic            hue_zero;
		logic            hue_neg;
		logic [CH_W-1:0] hue_off;
		logic            sat_zero;
		logic [CH_W-1:0] light;
	} side_t;

endpackage

@@ design/rgb565_hsl_color_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_hsl_color_classifier
// Converts RGB565 pixels to hue, saturation and lightness on a 0..240 scale
// and flags pixels whose three values lie strictly inside the set bounds.
//
//   channel   signals                          direction
//   pixel     pixel_valid/pixel_stall          word in: pixel_rgb565
//   result    result_valid/result_stall        word out: hue, saturation,
//                                              lightness, is_match
//   config    APB psel/penable/pwrite/paddr    six 8-bit bounds at 4*i
//
// One pixel per clock sustained while no result word is held; the path runs
// through two front stages, eight divider steps and one output register,
// the steps coming from the restoring divider that resolves one quotient bit per stage.
// Reset clears all valid bits and loads the default bounds.
// A result word held by result_stall freezes the whole pipeline and raises
// pixel_stall in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgb565_hsl_color_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// pixel channel
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [15:0] pixel_rgb565,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  hue,
	output logic [7:0]  saturation,
	output logic [7:0]  lightness,
	output logic        is_match,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rgbhsl_pkg::*;

	// bound registers
	logic [CH_W-1:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q;
	logic [CH_W-1:0] light_low_q, light_high_q;
	cfg_reg_t        reg_sel;
	logic            cfg_wr;

	// pipeline control
	logic adv;

	// stage 1
	logic [CH_W-1:0] r_c, g_c, b_c, mx_c, mn_c, mag_c, off_c;
	logic [CH_W:0]   diff_c, mag_full_c;
	logic            v_s1, neg_s1;
	logic [CH_W-1:0] mx_s1, mn_s1, mag_s1, off_s1;

	// stage 2
	logic [CH_W-1:0]   dif_c;
	logic [SDEN_W-1:0] sum_c, sden_c;
	logic [11:0]       sum8_c;
	logic [23:0]       lprod_c;
	logic              v_s2;
	logic [HNUM_W-1:0] hnum_s2;
	logic [HDEN_W-1:0] hden_s2;
	logic [SNUM_W-1:0] snum_s2;
	logic [SDEN_W-1:0] sden_s2;
	side_t             side_s2;

	// divider outputs
	logic            v_dv;
	logic [QUO_W-1:0] hq_dv, sq_dv;
	side_t           side_dv;

	// output stage
	logic [CH_W+1:0] h_wide;
	logic [CH_W-1:0] hue_c, sat_c;
	logic            match_c;
	logic            v_s4;
	logic [CH_W-1:0] hue_s4, sat_s4, light_s4;
	logic            match_s4;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// write bounds; unknown indexes drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q    <= 8'd60;
			hue_high_q   <= 8'd110;
			sat_low_q    <= 8'd15;
			sat_high_q   <= 8'd110;
			light_low_q  <= 8'd20;
			light_high_q <= 8'd210;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_HUE_LOW:    hue_low_q    <= pwdata[CH_W-1:0];
				REG_HUE_HIGH:   hue_high_q   <= pwdata[CH_W-1:0];
				REG_SAT_LOW:    sat_low_q    <= pwdata[CH_W-1:0];
				REG_SAT_HIGH:   sat_high_q   <= pwdata[CH_W-1:0];
				REG_LIGHT_LOW:  light_low_q  <= pwdata[CH_W-1:0];
				REG_LIGHT_HIGH: light_high_q <= pwdata[CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			REG_HUE_LOW:    prdata = 32'(hue_low_q);
			REG_HUE_HIGH:   prdata = 32'(hue_high_q);
			REG_SAT_LOW:    prdata = 32'(sat_low_q);
			REG_SAT_HIGH:   prdata = 32'(sat_high_q);
			REG_LIGHT_LOW:  prdata = 32'(light_low_q);
			REG_LIGHT_HIGH: prdata = 32'(light_high_q);
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- flow control ----------------
	// advance everything unless the output word is held
	assign adv         = !v_s4 || !result_stall;
	assign pixel_stall = !adv;

	// ---------------- stage 1: expand, max/min, hue sector ----------------
	assign r_c  = {pixel_rgb565[15:11], 3'b000};
	assign g_c  = {pixel_rgb565[10:5], 2'b00};
	assign b_c  = {pixel_rgb565[4:0], 3'b000};
	assign mx_c = (r_c > g_c) ? ((b_c > r_c) ? b_c : r_c) : ((b_c > g_c) ? b_c : g_c);
	assign mn_c = (r_c < g_c) ? ((b_c < r_c) ? b_c : r_c) : ((b_c < g_c) ? b_c : g_c);

	// pick the signed channel difference and offset for the sector
	always_comb begin
		if (mx_c == r_c && mn_c == b_c) begin
			diff_c = {1'b0, g_c} - {1'b0, b_c};
			off_c  = HUE_OFF_R_UP;
		end else if (mx_c == r_c) begin
			diff_c = {1'b0, g_c} - {1'b0, b_c};
			off_c  = HUE_OFF_R_DOWN;
		end else if (mx_c == g_c) begin
			diff_c = {1'b0, b_c} - {1'b0, r_c};
			off_c  = HUE_OFF_G;
		end else begin
			diff_c = {1'b0, r_c} - {1'b0, g_c};
			off_c  = HUE_OFF_B;
		end
	end

	assign mag_full_c = diff_c[CH_W] ? ((CH_W+1)'(0) - diff_c) : diff_c;
	assign mag_c      = mag_full_c[CH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			mag_s1 <= mag_c;
			neg_s1 <= diff_c[CH_W];
			off_s1 <= off_c;
		end
	end

	// ---------------- stage 2: numerators, divisors, lightness ----------------
	assign dif_c   = mx_s1 - mn_s1;
	assign sum_c   = {1'b0, mx_s1} + {1'b0, mn_s1};
	assign sum8_c  = {sum_c, 3'b000};
	assign lprod_c = 24'(sum8_c) * 24'(LIGHT_RECIP);
	assign sden_c  = (sum_c <= SUM_LOW_MAX) ? sum_c : (SUM_FULL - sum_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// 40*mag and 240*dif by shift and add
			hnum_s2          <= (HNUM_W'(mag_s1) << 5) + (HNUM_W'(mag_s1) << 3);
			snum_s2          <= (SNUM_W'(dif_c) << 8) - (SNUM_W'(dif_c) << 4);
			hden_s2          <= dif_c;
			sden_s2          <= sden_c;
			side_s2.hue_zero <= (dif_c == '0);
			side_s2.hue_neg  <= neg_s1;
			side_s2.hue_off  <= off_s1;
			side_s2.sat_zero <= (dif_c == '0) || (sum_c <= SUM_DARK_MAX) || (sden_c == '0);
			side_s2.light    <= lprod_c[LIGHT_SHIFT +: CH_W];
		end
	end

	// ---------------- stage 3: divider steps ----------------
	rgbhsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.hue_num   (hnum_s2),
		.hue_den   (hden_s2),
		.sat_num   (snum_s2),
		.sat_den   (sden_s2),
		.side_in   (side_s2),
		.out_valid (v_dv),
		.hue_quo   (hq_dv),
		.sat_quo   (sq_dv),
		.side_out  (side_dv)
	);

	// ---------------- stage 4: sign, offset, clamp, compare ----------------
	assign h_wide = side_dv.hue_neg ? ({2'b00, side_dv.hue_off} - {2'b00, hq_dv})
	                                : ({2'b00, side_dv.hue_off} + {2'b00, hq_dv});

	always_comb begin
		if (side_dv.hue_zero || h_wide[CH_W+1]) begin
			hue_c = '0;
		end else if (h_wide > {2'b00, SCALE_MAX}) begin
			hue_c = SCALE_MAX;
		end else begin
			hue_c = h_wide[CH_W-1:0];
		end

		if (side_dv.sat_zero) begin
			sat_c = '0;
		end else if (sq_dv > SCALE_MAX) begin
			sat_c = SCALE_MAX;
		end else begin
			sat_c = sq_dv;
		end
	end

	assign match_c = (hue_c > hue_low_q) && (hue_c < hue_high_q) &&
	                 (sat_c > sat_low_q) && (sat_c < sat_high_q) &&
	                 (side_dv.light > light_low_q) && (side_dv.light < light_high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s4   <= hue_c;
			sat_s4   <= sat_c;
			light_s4 <= side_dv.light;
			match_s4 <= match_c;
		end
	end

	assign result_valid = v_s4;
	assign hue          = hue_s4;
	assign saturation   = sat_s4;
	assign lightness    = light_s4;
	assign is_match     = match_s4;

`ifndef SYNTHESIS
	// outputs stay on the 0..240 scale
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (hue <= SCALE_MAX && saturation <= SCALE_MAX && lightness <= SCALE_MAX))
		else $error("result outside 0..240 scale");

	// a match needs nonzero hue and saturation
	a_match_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && is_match) |-> (hue != '0 && saturation != '0))
		else $error("match flagged with zero hue or saturation");

	// an accepted pixel enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) |=> v_s1)
		else $error("accepted pixel lost at stage 1");

	// a held pipeline keeps its first stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |=> ($stable(v_s1) && (!v_s1 || $stable(mx_s1)) && (!v_s1 || $stable(mn_s1))))
		else $error("stage 1 changed during stall");
`endif

endmodule

@@ design/rgbhsl_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_div
// Two-lane restoring divider, one quotient bit per pipeline stage, for the
// hue and saturation quotients. Valid and sideband travel with the data.
// ----------------------------------------------------------------------------
module rgbhsl_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [rgbhsl_pkg::HNUM_W-1:0]       hue_num,
	input  logic [rgbhsl_pkg::HDEN_W-1:0]       hue_den,
	input  logic [rgbhsl_pkg::SNUM_W-1:0]       sat_num,
	input  logic [rgbhsl_pkg::SDEN_W-1:0]       sat_den,
	input  rgbhsl_pkg::side_t                   side_in,
	output logic                                out_valid,
	output logic [rgbhsl_pkg::QUO_W-1:0]        hue_quo,
	output logic [rgbhsl_pkg::QUO_W-1:0]        sat_quo,
	output rgbhsl_pkg::side_t                   side_out
);
	import rgbhsl_pkg::*;

	localparam int unsigned HCMP_W = HDEN_W + QUO_W;
	localparam int unsigned SCMP_W = SDEN_W + QUO_W;

	// stage registers, one entry per quotient bit
	logic              valid_s3 [QUO_W];
	logic [HNUM_W-1:0] hrem_s3  [QUO_W];
	logic [HDEN_W-1:0] hden_s3  [QUO_W];
	logic [QUO_W-1:0]  hquo_s3  [QUO_W];
	logic [SNUM_W-1:0] srem_s3  [QUO_W];
	logic [SDEN_W-1:0] sden_s3  [QUO_W];
	logic [QUO_W-1:0]  squo_s3  [QUO_W];
	side_t             side_s3  [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int unsigned BIT = QUO_W - 1 - k;

		logic              v_in;
		logic [HNUM_W-1:0] hrem_in;
		logic [HDEN_W-1:0] hden_in;
		logic [QUO_W-1:0]  hquo_in;
		logic [SNUM_W-1:0] srem_in;
		logic [SDEN_W-1:0] sden_in;
		logic [QUO_W-1:0]  squo_in;
		side_t             side_in_k;
		logic [HCMP_W-1:0] htrial;
		logic [SCMP_W-1:0] strial;
		logic              hfit;
		logic              sfit;

		// pick up the previous stage, or the inputs at the head
		if (k == 0) begin : g_head
			assign v_in      = in_valid;
			assign hrem_in   = hue_num;
			assign hden_in   = hue_den;
			assign hquo_in   = '0;
			assign srem_in   = sat_num;
			assign sden_in   = sat_den;
			assign squo_in   = '0;
			assign side_in_k = side_in;
		end else begin : g_body
			assign v_in      = valid_s3[k-1];
			assign hrem_in   = hrem_s3[k-1];
			assign hden_in   = hden_s3[k-1];
			assign hquo_in   = hquo_s3[k-1];
			assign srem_in   = srem_s3[k-1];
			assign sden_in   = sden_s3[k-1];
			assign squo_in   = squo_s3[k-1];
			assign side_in_k = side_s3[k-1];
		end

		// trial subtract of the divisor aligned to this quotient bit
		assign htrial = HCMP_W'(hden_in) << BIT;
		assign strial = SCMP_W'(sden_in) << BIT;
		assign hfit   = HCMP_W'(hrem_in) >= htrial;
		assign sfit   = SCMP_W'(srem_in) >= strial;

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s3[k] <= 1'b0;
			end else if (en) begin
				valid_s3[k] <= v_in;
			end
		end

		// advance remainder, quotient and sideband
		always_ff @(posedge clk) begin
			if (en) begin
				hrem_s3[k] <= hfit ? HNUM_W'(HCMP_W'(hrem_in) - htrial) : hrem_in;
				srem_s3[k] <= sfit ? SNUM_W'(SCMP_W'(srem_in) - strial) : srem_in;
				hquo_s3[k] <= hquo_in | (hfit ? (QUO_W'(1) << BIT) : '0);
				squo_s3[k] <= squo_in | (sfit ? (QUO_W'(1) << BIT) : '0);
				hden_s3[k] <= hden_in;
				sden_s3[k] <= sden_in;
				side_s3[k] <= side_in_k;
			end
		end
	end

	assign out_valid = valid_s3[QUO_W-1];
	assign hue_quo   = hquo_s3[QUO_W-1];
	assign sat_quo   = squo_s3[QUO_W-1];
	assign side_out  = side_s3[QUO_W-1];

endmodule
